// ===== rtl/slot_table_allocator_assert.svh =====
// Assertion macros used by the top-level RTL.
`ifndef SLOT_TABLE_ALLOCATOR_ASSERT_SVH
`define SLOT_TABLE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define STA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slot_table_allocator: assertion failed");

// Next-cycle implication, checked out of reset.
`define STA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slot_table_allocator: assertion failed");

`endif

// ===== rtl/sta_pkg.sv =====
package sta_pkg;

  localparam int SLOTS         = 64;
  localparam int ELEMENT_BYTES = 8;
  localparam int SLOT_W        = $clog2(SLOTS);
  localparam int CNT_W         = $clog2(SLOTS + 1);
  localparam int ELEM_W        = 64;
  localparam int NB_W          = 4;
  localparam int OP_W          = 3;

  localparam logic [OP_W-1:0] OP_FILL      = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC     = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd2;
  localparam logic [OP_W-1:0] OP_READ      = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND      = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd5;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_step;
    logic find_issue;
    logic find_cap;
    logic empty_cap;
    logic read_cap;
    logic commit;
  } sta_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            auto_slot;
    logic            find_ok;
    logic            scan_end;
    logic            empty_now;
    logic            find_match;
    logic            cmp_valid;
    logic            out_free;
  } sta_stat_t;

  // Ones in the low nb bytes.
  function automatic logic [ELEM_W-1:0] byte_mask(input logic [NB_W-1:0] nb);
    logic [ELEM_W-1:0] m;
    m = '0;
    for (int b = 0; b < ELEM_W / 8; b++) begin
      if (NB_W'(b) < nb) m[8*b +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

// ===== rtl/sta_ram.sv =====
module sta_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sta_ctrl.sv =====
module sta_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sta_pkg::sta_stat_t stat,
  output sta_pkg::sta_cmd_t  cmd
);
  import sta_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_EMPTY    = 3'd2;
  localparam logic [2:0] S_FIND     = 3'd3;
  localparam logic [2:0] S_READ     = 3'd4;
  localparam logic [2:0] S_COMMIT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.scan_clr = 1'b1;
        unique case (stat.op)
          OP_FILL:  state_next = stat.auto_slot ? S_EMPTY : S_COMMIT;
          OP_ALLOC: state_next = S_EMPTY;
          OP_READ:  state_next = S_READ;
          OP_FIND:  state_next = stat.find_ok ? S_FIND : S_COMMIT;
          default:  state_next = S_COMMIT;
        endcase
      end
      S_EMPTY: begin
        priority if (stat.scan_end) begin
          state_next = S_COMMIT;
        end else if (stat.empty_now) begin
          cmd.empty_cap = 1'b1;
          state_next    = S_COMMIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FIND: begin
        cmd.find_cap = 1'b1;
        priority if (stat.find_match) begin
          state_next = S_COMMIT;
        end else if (stat.scan_end) begin
          // Let the last compare drain.
          if (!stat.cmp_valid) state_next = S_COMMIT;
        end else begin
          cmd.find_issue = 1'b1;
          cmd.scan_step  = 1'b1;
        end
      end
      S_READ: begin
        cmd.read_cap = 1'b1;
        state_next   = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/sta_dp.sv =====
module sta_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [sta_pkg::OP_W-1:0]    operation,
  input  logic                        auto_slot,
  input  logic [sta_pkg::SLOT_W-1:0]  slot,
  input  logic [sta_pkg::ELEM_W-1:0]  element,
  input  logic [sta_pkg::NB_W-1:0]    match_bytes,
  input  sta_pkg::sta_cmd_t           cmd,
  output sta_pkg::sta_stat_t          stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        ok,
  output logic [sta_pkg::SLOT_W-1:0]  slot_out,
  output logic [sta_pkg::ELEM_W-1:0]  element_out,
  output logic [sta_pkg::CNT_W-1:0]   used_count
);
  import sta_pkg::*;

  // Request registers
  logic [OP_W-1:0]   req_op;
  logic              req_auto;
  logic [SLOT_W-1:0] req_slot;
  logic [ELEM_W-1:0] req_key;
  logic [ELEM_W-1:0] req_mask;
  logic              req_find_ok;

  // Table state
  logic [SLOTS-1:0]  used;
  logic [CNT_W-1:0]  count;

  // Scan and search results
  logic [CNT_W-1:0]  scan_idx;
  logic              cmp_valid;
  logic [SLOT_W-1:0] cmp_idx;
  logic              found;
  logic [SLOT_W-1:0] found_idx;
  logic [ELEM_W-1:0] found_data;

  logic [SLOT_W-1:0] rd_addr;
  logic [ELEM_W-1:0] rd_data;
  logic              match;

  // Commit decisions
  logic              res_ok;
  logic [SLOT_W-1:0] res_slot;
  logic [ELEM_W-1:0] res_data;
  logic [SLOT_W-1:0] tgt;
  logic              do_write;
  logic              do_set;
  logic              do_clr;
  logic              do_clr_all;
  logic [CNT_W-1:0]  count_next;
  logic              in_range;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op      <= operation;
      req_auto    <= auto_slot;
      req_slot    <= slot;
      req_key     <= element & byte_mask(NB_W'(ELEMENT_BYTES));
      req_mask    <= byte_mask(match_bytes);
      req_find_ok <= (match_bytes <= NB_W'(ELEMENT_BYTES));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr)       scan_idx <= '0;
    else if (cmd.scan_step) scan_idx <= scan_idx + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) cmp_valid <= 1'b0;
    else     cmp_valid <= cmd.find_issue;
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx[SLOT_W-1:0];
  end

  assign rd_addr = cmd.find_issue ? scan_idx[SLOT_W-1:0] : req_slot;
  assign match   = cmp_valid && used[cmp_idx] && (((rd_data ^ req_key) & req_mask) == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found <= 1'b0;
    end else if (cmd.empty_cap) begin
      found     <= 1'b1;
      found_idx <= scan_idx[SLOT_W-1:0];
    end else if (cmd.find_cap && match) begin
      found      <= 1'b1;
      found_idx  <= cmp_idx;
      found_data <= rd_data;
    end else if (cmd.read_cap) begin
      found_data <= rd_data;
    end
  end

  sta_ram #(
    .WIDTH(ELEM_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (do_write),
    .waddr(tgt),
    .wdata(req_key),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign in_range = (CNT_W'(req_slot) < CNT_W'(SLOTS));

  always_comb begin
    res_ok     = 1'b0;
    res_slot   = '0;
    res_data   = '0;
    tgt        = req_slot;
    do_write   = 1'b0;
    do_set     = 1'b0;
    do_clr     = 1'b0;
    do_clr_all = 1'b0;
    count_next = count;
    unique case (req_op)
      OP_FILL: begin
        tgt = req_auto ? found_idx : req_slot;
        if (req_auto ? found : in_range) begin
          res_ok   = 1'b1;
          res_slot = tgt;
          do_write = cmd.commit;
          do_set   = 1'b1;
          if (!used[tgt]) count_next = count + CNT_W'(1);
        end
      end
      OP_ALLOC: begin
        tgt = found_idx;
        if (found) begin
          res_ok     = 1'b1;
          res_slot   = tgt;
          do_set     = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        if (in_range && used[req_slot]) begin
          res_ok     = 1'b1;
          res_slot   = req_slot;
          do_clr     = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (in_range && used[req_slot]) begin
          res_ok   = 1'b1;
          res_slot = req_slot;
          res_data = found_data;
        end
      end
      OP_FIND: begin
        if (found) begin
          res_ok   = 1'b1;
          res_slot = found_idx;
          res_data = found_data;
        end
      end
      OP_CLEAR_ALL: begin
        res_ok     = 1'b1;
        do_clr_all = 1'b1;
        count_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
      priority if (do_clr_all) used      <= '0;
      else if (do_set)         used[tgt] <= 1'b1;
      else if (do_clr)         used[tgt] <= 1'b0;
      else                     used      <= used;
    end
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst)             out_valid <= 1'b0;
    else if (cmd.commit) out_valid <= 1'b1;
    else if (out_ready)  out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ok          <= res_ok;
      slot_out    <= res_slot;
      element_out <= res_data;
      used_count  <= count_next;
    end
  end

  assign stat.op         = req_op;
  assign stat.auto_slot  = req_auto;
  assign stat.find_ok    = req_find_ok;
  assign stat.scan_end   = (scan_idx == CNT_W'(SLOTS));
  assign stat.empty_now  = !used[scan_idx[SLOT_W-1:0]];
  assign stat.find_match = match;
  assign stat.cmp_valid  = cmp_valid;
  assign stat.out_free   = !out_valid || out_ready;

endmodule

// ===== rtl/slot_table_allocator.sv =====
// Channel   Handshake             Payload
// in        in_valid / in_ready   operation, auto_slot, slot, element, match_bytes
// out       out_valid / out_ready ok, slot_out, element_out, used_count
//
// One request at a time. Clear, fixed fill, clear all and read need no scan;
// allocate and auto fill scan the used bits, one slot a cycle, and find reads
// the table memory, one slot a cycle, with each compare in the cycle after its read.
// Reset empties the table at once; the used bits are flip-flops, no clearing pass.
// A result waits in the output register; a new request is taken meanwhile, and its
// result is held back until the output beat is taken.
module slot_table_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sta_pkg::OP_W-1:0]    operation,
  input  logic                        auto_slot,
  input  logic [sta_pkg::SLOT_W-1:0]  slot,
  input  logic [sta_pkg::ELEM_W-1:0]  element,
  input  logic [sta_pkg::NB_W-1:0]    match_bytes,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        ok,
  output logic [sta_pkg::SLOT_W-1:0]  slot_out,
  output logic [sta_pkg::ELEM_W-1:0]  element_out,
  output logic [sta_pkg::CNT_W-1:0]   used_count
);
  import sta_pkg::*;

  sta_cmd_t  cmd;
  sta_stat_t stat;

  sta_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  sta_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .operation  (operation),
    .auto_slot  (auto_slot),
    .slot       (slot),
    .element    (element),
    .match_bytes(match_bytes),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .slot_out   (slot_out),
    .element_out(element_out),
    .used_count (used_count)
  );

`include "slot_table_allocator_assert.svh"

  `STA_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `STA_ASSERT_NOW(a_fail_zeroed, out_valid && !ok, slot_out == '0 && element_out == '0)
  `STA_ASSERT_NOW(a_count_bound, out_valid, used_count <= CNT_W'(SLOTS))
  `STA_ASSERT_NOW(a_commit_free, cmd.commit, stat.out_free)

endmodule

// ===== dv/tb.sv =====
module tb;
  import sta_pkg::*;

  localparam int N_ITEMS = 1600;
  localparam int END_WAIT = SLOTS + 40;

  // Codes the block leaves unused.
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              auto_slot;
    logic [SLOT_W-1:0] slot;
    logic [ELEM_W-1:0] element;
    logic [NB_W-1:0]   match_bytes;
  } slot_req_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [ELEM_W-1:0] element;
    logic [CNT_W-1:0]  count;
  } slot_answer_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   operation = '0;
  logic              auto_slot = 1'b0;
  logic [SLOT_W-1:0] slot = '0;
  logic [ELEM_W-1:0] element = '0;
  logic [NB_W-1:0]   match_bytes = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              ok;
  logic [SLOT_W-1:0] slot_out;
  logic [ELEM_W-1:0] element_out;
  logic [CNT_W-1:0]  used_count;

  slot_table_allocator dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .auto_slot   (auto_slot),
    .slot        (slot),
    .element     (element),
    .match_bytes (match_bytes),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ok          (ok),
    .slot_out    (slot_out),
    .element_out (element_out),
    .used_count  (used_count)
  );

  always #5 clk = ~clk;

  slot_req_t    pending_reqs[$];
  slot_answer_t answers_due[$];
  slot_req_t    held_req;
  int           n_items;
  int           accepted_cnt = 0;
  int           err_cnt = 0;

  // Predicted contents of the table, advanced on every accepted request.
  logic [ELEM_W-1:0] model_data [SLOTS];
  logic [SLOTS-1:0]  model_used = '0;
  logic [CNT_W-1:0]  model_count = '0;

  // Stimulus-side view: which slots are used and which hold written data.
  logic [ELEM_W-1:0] plan_data [SLOTS];
  logic [SLOTS-1:0]  plan_used = '0;
  logic [SLOTS-1:0]  plan_written = '0;

  function automatic logic [ELEM_W-1:0] low_bytes(input int nb);
    if (nb >= 8) return '1;
    return (64'd1 << (8 * nb)) - 64'd1;
  endfunction

  // Lowest clear bit, or SLOTS when all are set.
  function automatic int lowest_clear(input logic [SLOTS-1:0] marks);
    for (int i = 0; i < SLOTS; i++) begin
      if (!marks[i]) return i;
    end
    return SLOTS;
  endfunction

  function automatic slot_answer_t apply_request(input slot_req_t r);
    slot_answer_t      a;
    int                idx;
    logic [ELEM_W-1:0] m;
    logic [ELEM_W-1:0] e;
    a = '0;
    e = r.element & low_bytes(ELEMENT_BYTES);
    case (r.op)
      OP_FILL: begin
        idx = r.auto_slot ? lowest_clear(model_used) : int'(r.slot);
        if (idx < SLOTS) begin
          model_data[idx] = e;
          if (!model_used[idx]) begin
            model_used[idx] = 1'b1;
            model_count++;
          end
          a.ok = 1'b1;
          a.slot = SLOT_W'(idx);
        end
      end
      OP_ALLOC: begin
        idx = lowest_clear(model_used);
        if (idx < SLOTS) begin
          model_used[idx] = 1'b1;
          model_count++;
          a.ok = 1'b1;
          a.slot = SLOT_W'(idx);
        end
      end
      OP_CLEAR: begin
        if (model_used[r.slot]) begin
          model_used[r.slot] = 1'b0;
          model_count--;
          a.ok = 1'b1;
          a.slot = r.slot;
        end
      end
      OP_READ: begin
        if (model_used[r.slot]) begin
          a.ok = 1'b1;
          a.slot = r.slot;
          a.element = model_data[r.slot];
        end
      end
      OP_FIND: begin
        if (r.match_bytes <= ELEMENT_BYTES) begin
          m = low_bytes(int'(r.match_bytes));
          for (int i = 0; i < SLOTS; i++) begin
            if (!a.ok && model_used[i] && ((model_data[i] ^ e) & m) == '0) begin
              a.ok = 1'b1;
              a.slot = SLOT_W'(i);
              a.element = model_data[i];
            end
          end
        end
      end
      OP_CLEAR_ALL: begin
        model_used = '0;
        model_count = '0;
        a.ok = 1'b1;
      end
      default: ;
    endcase
    a.count = model_count;
    return a;
  endfunction

  function automatic logic [ELEM_W-1:0] rand_elem();
    logic [ELEM_W-1:0] e;
    int                r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    e = {$urandom, $urandom};
    // Share low bytes often so that short keys hit several slots.
    if (r < 12) e[15:0] = 16'($urandom_range(0, 3));
    return e;
  endfunction

  // Random used slot holding written data, or SLOTS if there is none.
  function automatic int pick_filled();
    int start;
    int i;
    start = $urandom_range(0, SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) begin
      i = (start + k) % SLOTS;
      if (plan_used[i] && plan_written[i]) return i;
    end
    return SLOTS;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic plan_request(input logic [OP_W-1:0] op, input logic a, input int s,
                              input logic [ELEM_W-1:0] e, input int nb);
    slot_req_t r;
    int        idx;
    r.op = op;
    r.auto_slot = a;
    r.slot = SLOT_W'(s);
    r.element = e;
    r.match_bytes = NB_W'(nb);
    pending_reqs.push_back(r);
    case (op)
      OP_FILL: begin
        idx = a ? lowest_clear(plan_used) : s;
        if (idx < SLOTS) begin
          plan_used[idx] = 1'b1;
          plan_written[idx] = 1'b1;
          plan_data[idx] = e & low_bytes(ELEMENT_BYTES);
        end
      end
      OP_ALLOC: begin
        idx = lowest_clear(plan_used);
        if (idx < SLOTS) plan_used[idx] = 1'b1;
      end
      OP_CLEAR:     plan_used[s] = 1'b0;
      OP_CLEAR_ALL: plan_used = '0;
      default: ;
    endcase
  endtask

  task automatic load_next();
    held_req = pending_reqs.pop_front();
    operation <= held_req.op;
    auto_slot <= held_req.auto_slot;
    slot <= held_req.slot;
    element <= held_req.element;
    match_bytes <= held_req.match_bytes;
  endtask

  // Request driver.
  int send_gap = 0;
  int in_calm = 0;

  always @(posedge clk) begin : drive_req
    int nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (in_valid && in_ready) begin
      answers_due.push_back(apply_request(held_req));
      accepted_cnt <= accepted_cnt + 1;
      if (in_calm > 0) in_calm <= in_calm - 1;
      else if ($urandom_range(0, 99) == 0) in_calm <= $urandom_range(30, 120);
      nxt = (in_calm > 0) ? 0 : pick_gap();
      if (nxt == 0 && pending_reqs.size() != 0) begin
        // Hold valid high and move straight to the next beat.
        load_next();
      end else begin
        in_valid <= 1'b0;
        send_gap <= nxt;
      end
    end else if (!in_valid) begin
      if (send_gap > 0) send_gap <= send_gap - 1;
      else if (pending_reqs.size() != 0) begin
        load_next();
        in_valid <= 1'b1;
      end
    end
  end

  // Result monitor.
  int hold_left = 0;
  int out_calm = 0;

  always @(posedge clk) begin : watch_out
    slot_answer_t want;
    int           nxt;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (out_valid && out_ready) begin
      if (answers_due.size() == 0) begin
        $error("result beat with no request outstanding");
        err_cnt++;
      end else begin
        want = answers_due.pop_front();
        if (ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, ok);
          err_cnt++;
        end
        if (slot_out !== want.slot) begin
          $error("slot_out: expected %0d, got %0d", want.slot, slot_out);
          err_cnt++;
        end
        if (element_out !== want.element) begin
          $error("element_out: expected %h, got %h", want.element, element_out);
          err_cnt++;
        end
        if (used_count !== want.count) begin
          $error("used_count: expected %0d, got %0d", want.count, used_count);
          err_cnt++;
        end
      end
      if (out_calm > 0) out_calm <= out_calm - 1;
      else if ($urandom_range(0, 99) == 0) out_calm <= $urandom_range(30, 120);
      nxt = (out_calm > 0) ? 0 : pick_gap();
      if (nxt > 0) begin
        out_ready <= 1'b0;
        hold_left <= nxt;
      end
    end else if (!out_ready) begin
      if (hold_left > 1) hold_left <= hold_left - 1;
      else begin
        hold_left <= 0;
        out_ready <= 1'b1;
      end
    end else if (out_calm == 0 && $urandom_range(0, 19) == 0) begin
      // Drop ready at random while no result beat is waiting.
      out_ready <= 1'b0;
      hold_left <= $urandom_range(1, 12);
    end
  end

  initial begin : run_test
    int                pick;
    int                s;
    int                hole;
    int                nb;
    logic [ELEM_W-1:0] key;

    // Empty table: failing read, clear and find.
    plan_request(OP_READ, 1'b0, 0, '0, 0);
    plan_request(OP_CLEAR, 1'b1, 5, '1, 15);
    plan_request(OP_FIND, 1'b0, 0, '0, 0);
    plan_request(OP_FILL, 1'b0, SLOTS - 1, '1, 8);
    plan_request(OP_FILL, 1'b0, 0, '0, 0);
    plan_request(OP_FILL, 1'b1, 40, 64'h0123_4567_89ab_cdef, 3);
    // Refill of a used slot keeps the count.
    plan_request(OP_FILL, 1'b0, SLOTS - 1, 64'h8000_0000_0000_0001, 0);
    plan_request(OP_READ, 1'b1, SLOTS - 1, '0, 0);
    plan_request(OP_FIND, 1'b0, 9, '1, 0);
    plan_request(OP_FIND, 1'b0, 0, 64'h0123_4567_89ab_cdef, 8);
    plan_request(OP_FIND, 1'b0, 0, 64'hffff_ffff_ffff_0001, 2);
    plan_request(OP_FIND, 1'b0, 0, 64'h0123_4567_89ab_cdef, 9);
    plan_request(OP_FIND, 1'b0, 0, '0, 15);
    plan_request(OP_FIND, 1'b1, 0, 64'h5555, 8);
    plan_request(OP_ALLOC, 1'b0, 33, '1, 0);
    plan_request(OP_FILL, 1'b0, 2, 64'haaaa_5555_aaaa_5555, 0);
    plan_request(OP_CLEAR, 1'b0, 0, '0, 0);
    plan_request(OP_READ, 1'b0, 0, '0, 0);
    plan_request(OP_READ, 1'b0, 2, '0, 0);
    plan_request(OP_SPARE_6, 1'b1, SLOTS - 1, '1, 15);
    plan_request(OP_SPARE_7, 1'b0, 1, '1, 8);
    plan_request(OP_CLEAR_ALL, 1'b0, 0, '0, 0);
    plan_request(OP_READ, 1'b0, 1, '0, 0);

    // Open with a run to a full table and past it.
    repeat (SLOTS + 3) begin
      plan_request(($urandom_range(0, 4) == 0) ? OP_ALLOC : OP_FILL, 1'b1,
                   $urandom_range(0, SLOTS - 1), rand_elem(), $urandom_range(0, 15));
    end

    while (pending_reqs.size() < N_ITEMS) begin
      pick = $urandom_range(0, 99);
      s = $urandom_range(0, SLOTS - 1);
      // Allocated slots whose memory was never written block reads and finds.
      hole = lowest_clear(~(plan_used & ~plan_written));
      if (hole < SLOTS && $urandom_range(0, 2) == 0) begin
        plan_request(OP_FILL, 1'b0, hole, rand_elem(), $urandom_range(0, 15));
      end else if (pick < 4) begin
        repeat (SLOTS - $countones(plan_used) + $urandom_range(1, 3)) begin
          plan_request(($urandom_range(0, 4) == 0) ? OP_ALLOC : OP_FILL, 1'b1,
                       $urandom_range(0, SLOTS - 1), rand_elem(), $urandom_range(0, 15));
        end
      end else if (pick < 22) begin
        plan_request(OP_FILL, 1'b0, s, rand_elem(), $urandom_range(0, 15));
      end else if (pick < 36) begin
        plan_request(OP_FILL, 1'b1, s, rand_elem(), $urandom_range(0, 15));
      end else if (pick < 44) begin
        plan_request(OP_ALLOC, 1'($urandom), s, rand_elem(), $urandom_range(0, 15));
      end else if (pick < 58) begin
        if ($urandom_range(0, 9) < 7 && $countones(plan_used) != 0) begin
          s = lowest_clear(~plan_used);
          if (pick_filled() < SLOTS && $urandom_range(0, 1) == 0) s = pick_filled();
        end
        plan_request(OP_CLEAR, 1'($urandom), s, rand_elem(), $urandom_range(0, 15));
      end else if (pick < 72) begin
        if ($urandom_range(0, 3) != 0 && pick_filled() < SLOTS) s = pick_filled();
        if (!(plan_used[s] && !plan_written[s]))
          plan_request(OP_READ, 1'($urandom), s, rand_elem(), $urandom_range(0, 15));
      end else if (pick < 94) begin
        if (hole == SLOTS) begin
          nb = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
          s = pick_filled();
          if (s < SLOTS && $urandom_range(0, 3) != 0)
            key = plan_data[s] ^ ({$urandom, $urandom} & ~low_bytes(nb));
          else
            key = rand_elem();
          plan_request(OP_FIND, 1'($urandom), $urandom_range(0, SLOTS - 1), key, nb);
        end
      end else if (pick < 97) begin
        plan_request(OP_CLEAR_ALL, 1'($urandom), s, rand_elem(), $urandom_range(0, 15));
      end else begin
        plan_request(($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7, 1'($urandom), s,
                     rand_elem(), $urandom_range(0, 15));
      end
    end
    n_items = pending_reqs.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (accepted_cnt != n_items || answers_due.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);

    if (err_cnt == 0 && answers_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10000000;
    $display("FAIL");
    $finish;
  end

endmodule
